// ===== hdl/pdht_pkg.sv =====
// ----------------------------------------------------------------------------
// pdht_pkg: shared types and constants for the peak/hold level tracker
// Field widths, register indexes, reset values and the per-channel state
// record used by the store and the update logic.
// ----------------------------------------------------------------------------
package pdht_pkg;

    localparam int PDHT_CHANNELS = 8;   // default channel count, range 1..64

    localparam int CHAN_W      = 3;
    localparam int SAMPLE_W    = 24;
    localparam int LEVEL_W     = 24;
    localparam int COUNT_W     = 21;
    localparam int COEF_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    localparam logic [COEF_W-1:0]  DECAY_COEF_RESET  = 32'd4294915787;
    localparam logic [COUNT_W-1:0] HOLD_LENGTH_RESET = 21'd288000;

    typedef enum logic [0:0] {
        REG_DECAY_COEF  = 1'b0,
        REG_HOLD_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0]  decay_coef;
        logic [COUNT_W-1:0] hold_length;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] hold;
        logic [COUNT_W-1:0] count;
    } chan_state_t;

endpackage

// ===== hdl/pdht_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pdht_cfg_regs: configuration registers
// Holds the decay coefficient and the hold length, written through a plain
// write port.
// ----------------------------------------------------------------------------
module pdht_cfg_regs
    import pdht_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_DECAY_COEF:  cfg_next.decay_coef  = cfg_wdata[COEF_W-1:0];
                REG_HOLD_LENGTH: cfg_next.hold_length = cfg_wdata[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decay_coef  <= DECAY_COEF_RESET;
            cfg_reg.hold_length <= HOLD_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/pdht_chan_store.sv =====
// ----------------------------------------------------------------------------
// pdht_chan_store: per-channel level state
// Decaying peak, held peak and hold countdown for each channel, one read
// port and one write port; cleared at reset.
// ----------------------------------------------------------------------------
module pdht_chan_store
    import pdht_pkg::*;
#(
    parameter  int CHANNELS = PDHT_CHANNELS,
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] rd_idx,
    output chan_state_t      rd_state,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  chan_state_t      wr_state
);

    chan_state_t state_reg [CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else if (wr_en) begin
            state_reg[wr_idx] <= wr_state;
        end
    end

    assign rd_state = state_reg[rd_idx];

endmodule

// ===== hdl/pdht_level_update.sv =====
// ----------------------------------------------------------------------------
// pdht_level_update: one-sample level update
// Sample magnitude, decay of peak and held level, hold countdown.
// ----------------------------------------------------------------------------
module pdht_level_update
    import pdht_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample,
    input  cfg_t                       cfg,
    input  chan_state_t                cur_state,
    output chan_state_t                new_state
);

    function automatic logic [LEVEL_W-1:0] decay(input logic [LEVEL_W-1:0] level,
                                                 input logic [COEF_W-1:0]  coef);
        logic [LEVEL_W+COEF_W-1:0] prod;
        prod = {{COEF_W{1'b0}}, level} * {{LEVEL_W{1'b0}}, coef};
        return prod[LEVEL_W+COEF_W-1:COEF_W];
    endfunction

    logic [LEVEL_W-1:0] raw;
    logic [LEVEL_W-1:0] mag;
    logic [LEVEL_W-1:0] peak_dec;
    logic [LEVEL_W-1:0] hold_dec;

    // -2^23 wraps to 0x800000, which is its magnitude as unsigned
    assign raw      = sample;
    assign mag      = raw[LEVEL_W-1] ? (~raw + LEVEL_W'(1)) : raw;
    assign peak_dec = decay(cur_state.peak, cfg.decay_coef);
    assign hold_dec = decay(cur_state.hold, cfg.decay_coef);

    always_comb begin
        new_state.peak = (mag > peak_dec) ? mag : peak_dec;
        priority if (mag > cur_state.hold) begin
            new_state.hold  = mag;
            new_state.count = cfg.hold_length;
        end else if (cur_state.count != '0) begin
            new_state.hold  = cur_state.hold;
            new_state.count = cur_state.count - COUNT_W'(1);
        end else begin
            new_state.hold  = hold_dec;
            new_state.count = cur_state.count;
        end
    end

endmodule

// ===== hdl/peak_decay_hold_tracker_core.sv =====
// ----------------------------------------------------------------------------
// peak_decay_hold_tracker_core: per-channel peak meter with hold and decay
// Input register, combinational channel update, result register.
// ----------------------------------------------------------------------------
// Accepts one sample per clock while the output is not stalled and returns one result per
// sample, passed through the input register and then the result register. The channel
// state lives in flip-flops and is read, updated and written back while the sample sits in
// the input register (two 24x32 decay multipliers in parallel, then compare and select), so
// consecutive samples of the same channel need no wait. A channel index at or above
// CHANNELS leaves all state alone and reports zero levels. Configuration writes must
// only be issued while no sample is in flight.
// ----------------------------------------------------------------------------
module peak_decay_hold_tracker_core
    import pdht_pkg::*;
#(
    parameter int CHANNELS = PDHT_CHANNELS   // 1..64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // sample stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [2:0] channel, [26:3] sample
    // level stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [2:0] out_channel, [26:3] peak_level,
                                              // [50:27] hold_level
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SEL_W = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;

    cfg_t        cfg;
    chan_state_t cur_state;
    chan_state_t new_state;

    logic                       in_valid_reg, in_valid_next;
    logic [CHAN_W-1:0]          in_chan_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;

    logic                out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]   out_chan_reg;
    logic [LEVEL_W-1:0]  out_peak_reg;
    logic [LEVEL_W-1:0]  out_hold_reg;

    logic             advance;
    logic             in_range;
    logic [SEL_W-1:0] chan_ext;
    logic [IDX_W-1:0] chan_idx;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign chan_ext = SEL_W'(in_chan_reg);
    assign chan_idx = chan_ext[IDX_W-1:0];
    assign in_range = (32'(in_chan_reg) < CHANNELS);

    pdht_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdht_chan_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (chan_idx),
        .rd_state (cur_state),
        .wr_en    (advance && in_range),
        .wr_idx   (chan_idx),
        .wr_state (new_state)
    );

    pdht_level_update u_update (
        .sample    (in_sample_reg),
        .cfg       (cfg),
        .cur_state (cur_state),
        .new_state (new_state)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_chan_reg   <= s_tdata[CHAN_W-1:0];
            in_sample_reg <= s_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
        end
        if (advance) begin
            out_chan_reg <= in_chan_reg;
            out_peak_reg <= in_range ? new_state.peak : '0;
            out_hold_reg <= in_range ? new_state.hold : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - CHAN_W - 2*LEVEL_W)'(0),
                       out_hold_reg, out_peak_reg, out_chan_reg};

    // a sample moved to the result stage shows up as valid next cycle
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result stage not filled after update");

    // a stalled sample in the input stage is kept
    a_in_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_chan_reg)
                                        && $stable(in_sample_reg)))
        else $error("input stage lost a stalled sample");

    // levels never exceed full scale
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_peak_reg <= 24'h800000 && out_hold_reg <= 24'h800000))
        else $error("level above full scale");

    // an item is taken only into an empty or draining input stage
    a_accept_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!in_valid_reg || advance))
        else $error("input stage overwritten");

endmodule
